@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. The clock is clk, the reset is rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/hpr_pkg.sv @@
// ---------------------------------------------------------------------------
// hpr_pkg
// Shared constants for the hazard pointer reclaim unit.
// ---------------------------------------------------------------------------
package hpr_pkg;

  localparam int ADDR_W           = 48;
  localparam int CMD_W            = 2;
  localparam int TID_W            = 3;
  localparam int SLOT_W           = 1;
  localparam int THR_W            = 6;

  localparam int NUM_THREADS      = 8;
  localparam int SLOTS_PER_THREAD = 2;
  localparam int HAZARD_COUNT     = 16;
  localparam int RETIRE_DEPTH     = 64;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

  localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RETIRE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd2;

endpackage

@@ sv/hazard_pointer_reclaim_unit.sv @@
// ---------------------------------------------------------------------------
// hazard_pointer_reclaim_unit
// Hazard slot table, retire list and reclamation scan with freed-word output.
// ---------------------------------------------------------------------------
// One word is taken at a time. An assign, an unknown command or a retire
// that does not reach the threshold returns one empty result word. A scan
// (retire at threshold, or thread exit) walks the retire list through its
// single read port, one entry per cycle; freed addresses go into a free
// buffer memory and are then sent out one word at a time, each read from
// that buffer's read port and then loaded into the output register once the
// output slot is free, or as one empty word when nothing was freed. Every
// retired entry is compared against all nonzero hazard slots in parallel.
// Neither memory needs clearing after reset, so words are taken right away.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hazard_pointer_reclaim_unit #(
  parameter int HAZARD_COUNT = hpr_pkg::HAZARD_COUNT,
  parameter int RETIRE_DEPTH = hpr_pkg::RETIRE_DEPTH,
  localparam int CNT_W       = $clog2(RETIRE_DEPTH + 1),
  localparam int AW          = $clog2(RETIRE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hpr_pkg::THR_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hpr_pkg::CMD_W-1:0]  cmd,
  input  logic [hpr_pkg::TID_W-1:0]  thread_id,
  input  logic [hpr_pkg::SLOT_W-1:0] slot_index,
  input  logic [hpr_pkg::ADDR_W-1:0] address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       freed_valid,
  output logic [hpr_pkg::ADDR_W-1:0] freed_address,
  output logic                       last,
  output logic [CNT_W-1:0]           retained_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EMRD  = 3'd2;
  localparam logic [2:0] S_EMLD  = 3'd3;
  localparam logic [2:0] S_EMPTY = 3'd4;

  logic [2:0]                  state;
  logic [hpr_pkg::THR_W-1:0]   threshold;
  logic [CNT_W-1:0]            retire_count;
  logic [hpr_pkg::ADDR_W-1:0]  slots [HAZARD_COUNT];

  logic [CNT_W-1:0]            sidx;
  logic                        pvalid;
  logic [CNT_W-1:0]            kept;
  logic [CNT_W-1:0]            fcnt;
  logic [AW-1:0]               fidx;

  // retire list memory
  logic [hpr_pkg::ADDR_W-1:0]  rl_mem [RETIRE_DEPTH];
  logic                        rl_we;
  logic [AW-1:0]               rl_waddr;
  logic [hpr_pkg::ADDR_W-1:0]  rl_wdata;
  logic                        rl_re;
  logic [hpr_pkg::ADDR_W-1:0]  rl_rdata;

  // free buffer memory
  logic [hpr_pkg::ADDR_W-1:0]  fb_mem [RETIRE_DEPTH];
  logic                        fb_we;
  logic                        fb_re;
  logic [hpr_pkg::ADDR_W-1:0]  fb_rdata;

  logic                        accept;
  logic                        rl_full;
  logic [CNT_W-1:0]            count_after;
  logic                        scan_on_retire;
  logic                        hit;
  logic                        slot_free;
  logic                        out_load;
  logic                        em_last;
  logic [HAZARD_COUNT-1:0]     assign_hit;
  logic [HAZARD_COUNT-1:0]     exit_hit;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign out_load  = slot_free && (state == S_EMLD || state == S_EMPTY);

  assign rl_full        = (retire_count == CNT_W'(RETIRE_DEPTH));
  assign count_after    = rl_full ? retire_count : retire_count + CNT_W'(1);
  assign scan_on_retire = (int'(count_after) >= int'(threshold));
  assign em_last        = ((CNT_W'(fidx) + CNT_W'(1)) == fcnt);

  // slot decode for assign and exit
  always_comb begin
    for (int j = 0; j < HAZARD_COUNT; j++) begin
      assign_hit[j] = (int'(thread_id) < hpr_pkg::NUM_THREADS) &&
                      (int'(slot_index) < hpr_pkg::SLOTS_PER_THREAD) &&
                      (int'(thread_id) * hpr_pkg::SLOTS_PER_THREAD + int'(slot_index) == j);
      exit_hit[j]   = (int'(thread_id) < hpr_pkg::NUM_THREADS) &&
                      ((j / hpr_pkg::SLOTS_PER_THREAD) == int'(thread_id));
    end
  end

  // scanned entry against every nonzero hazard slot
  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < HAZARD_COUNT; j++) begin
      if (slots[j] != '0 && slots[j] == rl_rdata) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    rl_re    = (state == S_SCAN) && (sidx < retire_count);
    rl_we    = 1'b0;
    rl_waddr = retire_count[AW-1:0];
    rl_wdata = address;
    if (state == S_IDLE) begin
      rl_we = accept && (cmd == hpr_pkg::CMD_RETIRE) && !rl_full;
    end else if (state == S_SCAN) begin
      // kept entries compact toward the head; kept never passes sidx
      rl_we    = pvalid && hit;
      rl_waddr = kept[AW-1:0];
      rl_wdata = rl_rdata;
    end
    fb_we = (state == S_SCAN) && pvalid && !hit;
    fb_re = (state == S_EMRD);
  end

  always_ff @(posedge clk) begin
    if (rl_we) begin
      rl_mem[rl_waddr] <= rl_wdata;
    end
    if (rl_re) begin
      rl_rdata <= rl_mem[sidx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fcnt[AW-1:0]] <= rl_rdata;
    end
    if (fb_re) begin
      fb_rdata <= fb_mem[fidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      threshold    <= hpr_pkg::THR_RESET;
      retire_count <= '0;
      out_valid    <= 1'b0;
      pvalid       <= 1'b0;
      sidx         <= '0;
      kept         <= '0;
      fcnt         <= '0;
      fidx         <= '0;
      for (int j = 0; j < HAZARD_COUNT; j++) begin
        slots[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            sidx   <= '0;
            kept   <= '0;
            fcnt   <= '0;
            pvalid <= 1'b0;
            case (cmd)
              hpr_pkg::CMD_ASSIGN: begin
                for (int j = 0; j < HAZARD_COUNT; j++) begin
                  if (assign_hit[j]) begin
                    slots[j] <= address;
                  end
                end
                state <= S_EMPTY;
              end
              hpr_pkg::CMD_RETIRE: begin
                retire_count <= count_after;
                state        <= scan_on_retire ? S_SCAN : S_EMPTY;
              end
              hpr_pkg::CMD_EXIT: begin
                for (int j = 0; j < HAZARD_COUNT; j++) begin
                  if (exit_hit[j]) begin
                    slots[j] <= '0;
                  end
                end
                state <= S_SCAN;
              end
              default: begin
                state <= S_EMPTY;
              end
            endcase
          end
        end
        S_SCAN: begin
          pvalid <= rl_re;
          if (rl_re) begin
            sidx <= sidx + CNT_W'(1);
          end
          if (pvalid) begin
            if (hit) begin
              kept <= kept + CNT_W'(1);
            end else begin
              fcnt <= fcnt + CNT_W'(1);
            end
          end
          if (!rl_re && !pvalid) begin
            retire_count <= kept;
            fidx         <= '0;
            state        <= (fcnt == '0) ? S_EMPTY : S_EMRD;
          end
        end
        S_EMRD: begin
          state <= S_EMLD;
        end
        S_EMLD: begin
          if (slot_free) begin
            if (em_last) begin
              state <= S_IDLE;
            end else begin
              fidx  <= fidx + AW'(1);
              state <= S_EMRD;
            end
          end
        end
        S_EMPTY: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (state == S_EMLD && slot_free) begin
      freed_valid    <= 1'b1;
      freed_address  <= fb_rdata;
      last           <= em_last;
      retained_count <= retire_count;
    end else if (state == S_EMPTY && slot_free) begin
      freed_valid    <= 1'b0;
      freed_address  <= '0;
      last           <= 1'b1;
      retained_count <= retire_count;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, retire_count <= CNT_W'(RETIRE_DEPTH), "retire count past depth")
  `ASSERT_IMPLIES(a_scan_sum, state == S_SCAN, kept + fcnt <= sidx, "scan tally exceeds reads")
  `ASSERT_IMPLIES(a_scan_pipe, state == S_SCAN && pvalid, kept + fcnt < sidx, "scan entry lost")
  `ASSERT_IMPLIES(a_empty_last, out_valid && !freed_valid, last, "empty word not marked last")

endmodule
